// ===== sv/fifo_wait_time_monitor_defines.svh =====
// ----------------------------------------------------------------------------
// FIFO wait-time monitor assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_WAIT_TIME_MONITOR_DEFINES_SVH
`define FIFO_WAIT_TIME_MONITOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define FWTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FWTM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/fwtm_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO wait-time monitor package
// Sizes, command and status codes, and the control bundle of the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package fwtm_pkg;

    // Queue depth and timestamp width.
    localparam int DEPTH     = 64;
    localparam int TIME_BITS = 32;

    // Widths of the request and result fields.
    localparam int CMD_W    = 1;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int WAIT_W   = 32;
    localparam int SUM_W    = 48;
    localparam int LINE_W   = 7;
    localparam int SERVED_W = 32;

    // Occupancy counter must hold DEPTH itself.
    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENTER = 1'b0,
        CMD_EXIT  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY_EXIT = 2'd1,
        STAT_FULL_DROP  = 2'd2,
        STAT_HALTED     = 2'd3
    } status_t;

    // Control shared by every cell of the row.
    typedef struct packed {
        logic push;
        logic pop;
    } fwtm_ctl_t;

endpackage

`default_nettype wire

// ===== sv/fwtm_if.sv =====
// ----------------------------------------------------------------------------
// FIFO wait-time monitor channels
// Valid/ready channels for event requests and for result requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwtm_in_if
    import fwtm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [STAMP_W-1:0] time_stamp;

    modport source (output valid, output cmd, output time_stamp, input ready);
    modport sink   (input valid, input cmd, input time_stamp, output ready);
endinterface

interface fwtm_out_if
    import fwtm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WAIT_W-1:0]   wait_time;
    logic [SUM_W-1:0]    total_wait;
    logic [LINE_W-1:0]   in_line;
    logic [SERVED_W-1:0] served_count;

    modport source (output valid, output status, output wait_time, output total_wait,
                    output in_line, output served_count, input ready);
    modport sink   (input valid, input status, input wait_time, input total_wait,
                    input in_line, input served_count, output ready);
endinterface

`default_nettype wire

// ===== sv/fifo_wait_time_monitor.sv =====
// ----------------------------------------------------------------------------
// FIFO wait-time monitor: queue of arrival timestamps with wait statistics.
// Output: the result of an accepted request is registered and offered in the next cycle.
// Throughput: one request per cycle while results are taken; the single result
// register holds the event side off for as long as the result side does.
// Reset: asynchronous and active low; queue empty, counters zero, halt cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fifo_wait_time_monitor_defines.svh"

module fifo_wait_time_monitor
    import fwtm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fwtm_in_if.sink    events,
    fwtm_out_if.source results
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [WAIT_W-1:0]    wait_reg;
    logic [WAIT_W-1:0]    wait_next;

    logic [OCC_W-1:0]     occupancy_reg;
    logic [OCC_W-1:0]     occupancy_next;
    logic [SUM_W-1:0]     wait_sum_reg;
    logic [SUM_W-1:0]     wait_sum_next;
    logic [SERVED_W-1:0]  served_reg;
    logic [SERVED_W-1:0]  served_next;
    logic                 halted_reg;
    logic                 halted_next;

    logic                 accept;
    logic                 is_exit;
    logic                 empty;
    logic                 full;
    logic [TIME_BITS-1:0] t_in;
    logic [TIME_BITS-1:0] head_data;
    logic [TIME_BITS-1:0] wait_calc;
    logic [SUM_W:0]       sum_wide;
    logic [DEPTH-1:0]     occ_flags;
    fwtm_ctl_t            ctl;

    // A new request is taken when the result slot is free or drains now.
    assign events.ready = !out_valid_reg || results.ready;
    assign accept       = events.valid && events.ready;

    assign is_exit = (cmd_t'(events.cmd) == CMD_EXIT);
    assign t_in    = TIME_BITS'(events.time_stamp);
    assign empty   = (occupancy_reg == '0);
    assign full    = (occupancy_reg == OCC_W'(DEPTH));

    assign ctl.push = accept && !halted_reg && !is_exit && !full;
    assign ctl.pop  = accept && !halted_reg && is_exit && !empty;

    fwtm_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .t_in      (t_in),
        .head_data (head_data),
        .occ_flags (occ_flags)
    );

    assign wait_calc = t_in - head_data;
    // A carry out of the extended add means the total has saturated.
    assign sum_wide  = {1'b0, wait_sum_reg} + (SUM_W + 1)'(wait_calc);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        wait_next      = wait_reg;
        occupancy_next = occupancy_reg;
        wait_sum_next  = wait_sum_reg;
        served_next    = served_reg;
        halted_next    = halted_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            wait_next      = '0;
            if (halted_reg)
            begin
                status_next = STAT_HALTED;
            end
            else if (!is_exit)
            begin
                if (full)
                begin
                    status_next = STAT_FULL_DROP;
                end
                else
                begin
                    status_next    = STAT_OK;
                    occupancy_next = occupancy_reg + 1'b1;
                end
            end
            else if (empty)
            begin
                status_next = STAT_EMPTY_EXIT;
                halted_next = 1'b1;
            end
            else
            begin
                status_next    = STAT_OK;
                wait_next      = WAIT_W'(wait_calc);
                occupancy_next = occupancy_reg - 1'b1;
                wait_sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                if (served_reg != '1)
                begin
                    served_next = served_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            occupancy_reg <= '0;
            wait_sum_reg  <= '0;
            served_reg    <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            occupancy_reg <= occupancy_next;
            wait_sum_reg  <= wait_sum_next;
            served_reg    <= served_next;
            halted_reg    <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        wait_reg   <= wait_next;
    end

    // Counters only move when a request is accepted, so they stay in step
    // with the result being offered.
    assign results.valid        = out_valid_reg;
    assign results.status       = status_reg;
    assign results.wait_time    = wait_reg;
    assign results.total_wait   = wait_sum_reg;
    assign results.in_line      = LINE_W'(occupancy_reg);
    assign results.served_count = served_reg;

    `FWTM_ASSERT_NOW(a_occ_count, clk, rst_n, 1'b1, $countones(occ_flags) == occupancy_reg)
    `FWTM_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg)
    `FWTM_ASSERT_NOW(a_halt_no_move, clk, rst_n, halted_reg, !ctl.push && !ctl.pop)
    `FWTM_ASSERT_NEXT(a_pop_served, clk, rst_n, ctl.pop && (served_reg != '1),
                      served_reg == $past(served_reg) + 1'b1)

endmodule

`default_nettype wire

// ===== sv/fwtm_cell.sv =====
// ----------------------------------------------------------------------------
// FIFO wait-time monitor cell
// One queue slot: holds a timestamp and an occupied flag, shifts toward the
// head on a pop and captures a new timestamp when it is the first free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fwtm_cell
    import fwtm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fwtm_ctl_t            ctl,
    input  wire logic [TIME_BITS-1:0] t_in,
    input  wire logic                 prev_occ,
    input  wire logic                 next_occ,
    input  wire logic [TIME_BITS-1:0] next_data,
    output logic                      occ,
    output logic [TIME_BITS-1:0]      data
);

    logic                 occ_reg;
    logic                 occ_next;
    logic [TIME_BITS-1:0] data_reg;
    logic [TIME_BITS-1:0] data_next;
    logic                 load;

    // The tail slot is the first empty cell behind an occupied one.
    assign load = ctl.push && !occ_reg && prev_occ;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (ctl.pop)
        begin
            occ_next  = next_occ;
            data_next = next_data;
        end
        else if (load)
        begin
            occ_next  = 1'b1;
            data_next = t_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign occ  = occ_reg;
    assign data = data_reg;

endmodule

`default_nettype wire

// ===== sv/fwtm_chain.sv =====
// ----------------------------------------------------------------------------
// FIFO wait-time monitor cell row
// DEPTH cells in a line; cell 0 is the head of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fwtm_chain
    import fwtm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fwtm_ctl_t            ctl,
    input  wire logic [TIME_BITS-1:0] t_in,
    output logic [TIME_BITS-1:0]      head_data,
    output logic [DEPTH-1:0]          occ_flags
);

    logic [DEPTH-1:0]     occ_w;
    logic [TIME_BITS-1:0] data_w [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 prev_occ;
        logic                 next_occ;
        logic [TIME_BITS-1:0] next_data;

        if (i == 0)
        begin : g_head
            assign prev_occ = 1'b1;
        end
        else
        begin : g_body
            assign prev_occ = occ_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_occ  = 1'b0;
            assign next_data = '0;
        end
        else
        begin : g_link
            assign next_occ  = occ_w[i+1];
            assign next_data = data_w[i+1];
        end

        fwtm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .t_in      (t_in),
            .prev_occ  (prev_occ),
            .next_occ  (next_occ),
            .next_data (next_data),
            .occ       (occ_w[i]),
            .data      (data_w[i])
        );
    end

    assign head_data = data_w[0];
    assign occ_flags = occ_w;

endmodule

`default_nettype wire
